[design/scalar_kalman_filter_top_assert.svh]
// Assertion macros shared by the filter modules.
// Each use expands to one labeled concurrent assertion on clock, muted in reset.
`ifndef SCALAR_KALMAN_FILTER_TOP_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SKF_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("skf: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SKF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("skf: next-cycle check failed");

`endif

[design/skf_pkg.sv]
package skf_pkg;

   // field widths
   localparam int SampleWidth   = 16;
   localparam int EstWidth      = 32;
   localparam int CsrIndexWidth = 8;
   localparam int CsrDataWidth  = 32;
   localparam int GainWidth     = 16;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] REG_PROCESS_NOISE     = 8'd0;
   localparam logic [CsrIndexWidth-1:0] REG_MEASUREMENT_NOISE = 8'd1;

   // register reset values (Q16.16)
   localparam logic [CsrDataWidth-1:0] ProcessNoiseReset     = 32'd26214400;
   localparam logic [CsrDataWidth-1:0] MeasurementNoiseReset = 32'd655360;

   // datapath operations, one per microcode step
   localparam logic [2:0] OP_WAIT  = 3'd0;  // take sample, predict covariance
   localparam logic [2:0] OP_DEN   = 3'd1;  // denominator, divider setup, innovation
   localparam logic [2:0] OP_DIV   = 3'd2;  // one quotient bit
   localparam logic [2:0] OP_GAIN  = 3'd3;  // gain with special cases
   localparam logic [2:0] OP_MUL_P = 3'd4;  // (1 - K) * P_mid
   localparam logic [2:0] OP_UPD_P = 3'd5;  // write covariance
   localparam logic [2:0] OP_MUL_X = 3'd6;  // K * (z - x)
   localparam logic [2:0] OP_UPD_X = 3'd7;  // write estimate and result

   // jump conditions
   localparam logic [1:0] COND_NONE     = 2'd0;  // fall through
   localparam logic [1:0] COND_NO_REQ   = 2'd1;  // no sample offered
   localparam logic [1:0] COND_DIV_MORE = 2'd2;  // quotient bits left
   localparam logic [1:0] COND_OUT_BUSY = 2'd3;  // result register still held

   // program steps; the program fills the step space, so the last step wraps to 0
   localparam int PcWidth = 3;
   localparam logic [PcWidth-1:0] STEP_WAIT  = 3'd0;
   localparam logic [PcWidth-1:0] STEP_DEN   = 3'd1;
   localparam logic [PcWidth-1:0] STEP_DIV   = 3'd2;
   localparam logic [PcWidth-1:0] STEP_GAIN  = 3'd3;
   localparam logic [PcWidth-1:0] STEP_MUL_P = 3'd4;
   localparam logic [PcWidth-1:0] STEP_UPD_P = 3'd5;
   localparam logic [PcWidth-1:0] STEP_MUL_X = 3'd6;
   localparam logic [PcWidth-1:0] STEP_UPD_X = 3'd7;

   // division loop counter
   localparam int DivCntWidth = $clog2(GainWidth);
   localparam logic [DivCntWidth-1:0] DivLast = DivCntWidth'(GainWidth - 1);

   typedef struct packed {
      logic [2:0]         op;
      logic [1:0]         cond;
      logic [PcWidth-1:0] target;
   } skf_uword_type;

   typedef struct packed {
      logic [2:0] op;
      logic       fire;  // the step's register updates take effect
   } skf_ctrl_type;

   // microcode ROM
   function automatic skf_uword_type skf_ucode(input logic [PcWidth-1:0] step);
      skf_uword_type w;
      case (step)
         STEP_WAIT:  w = '{op: OP_WAIT,  cond: COND_NO_REQ,   target: STEP_WAIT};
         STEP_DEN:   w = '{op: OP_DEN,   cond: COND_NONE,     target: STEP_WAIT};
         STEP_DIV:   w = '{op: OP_DIV,   cond: COND_DIV_MORE, target: STEP_DIV};
         STEP_GAIN:  w = '{op: OP_GAIN,  cond: COND_NONE,     target: STEP_WAIT};
         STEP_MUL_P: w = '{op: OP_MUL_P, cond: COND_NONE,     target: STEP_WAIT};
         STEP_UPD_P: w = '{op: OP_UPD_P, cond: COND_NONE,     target: STEP_WAIT};
         STEP_MUL_X: w = '{op: OP_MUL_X, cond: COND_NONE,     target: STEP_WAIT};
         STEP_UPD_X: w = '{op: OP_UPD_X, cond: COND_OUT_BUSY, target: STEP_UPD_X};
         default:    w = '{op: OP_WAIT,  cond: COND_NONE,     target: STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

[design/skf_dpath.sv]
`include "scalar_kalman_filter_top_assert.svh"

module skf_dpath
   import skf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  skf_ctrl_type               ctrl,
   input  logic signed [SampleWidth-1:0] req_sample,
   input  logic [CsrDataWidth-1:0]    process_noise,
   input  logic [CsrDataWidth-1:0]    measurement_noise,
   output logic signed [EstWidth-1:0] rsp_estimate
);

   // filter state
   logic signed [31:0] est_ff, est_in;
   logic [31:0]        cov_ff, cov_in;

   // per-item working registers
   logic signed [31:0] z_ff, z_in;
   logic [31:0]        pmid_ff, pmid_in;
   logic [32:0]        den_ff, den_in;
   logic [32:0]        rem_ff, rem_in;
   logic [GainWidth-1:0] quo_ff, quo_in;
   logic [GainWidth-1:0] gain_ff, gain_in;
   logic signed [32:0] diff_ff, diff_in;
   logic signed [50:0] prod_ff, prod_in;
   logic signed [31:0] out_ff, out_in;

   logic [32:0]        pred_sum;
   logic [33:0]        rem_sh;
   logic [33:0]        den_ext;
   logic               rem_ge;
   logic signed [32:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [50:0] mul_prod;
   logic signed [35:0] upd_sum;
   logic signed [31:0] upd_sat;

   // prediction P + Q, saturating
   assign pred_sum = {1'b0, cov_ff} + {1'b0, process_noise};

   // restoring divider step
   assign rem_sh  = {rem_ff, 1'b0};
   assign den_ext = {1'b0, den_ff};
   assign rem_ge  = (rem_sh >= den_ext);

   // shared multiplier operands
   always_comb begin
      if (ctrl.op == OP_MUL_P) begin
         mul_a = $signed({1'b0, pmid_ff});
         mul_b = $signed({1'b0, 17'h10000 - {1'b0, gain_ff}});
      end else begin
         mul_a = diff_ff;
         mul_b = $signed({2'b00, gain_ff});
      end
   end
   assign mul_prod = mul_a * mul_b;

   // x + floor(prod / 2^16), clamped to 32 bits
   assign upd_sum = {{4{est_ff[31]}}, est_ff} + {prod_ff[50], prod_ff[50:16]};
   always_comb begin
      if (upd_sum[35:31] == 5'b00000 || upd_sum[35:31] == 5'b11111) begin
         upd_sat = upd_sum[31:0];
      end else if (upd_sum[35]) begin
         upd_sat = 32'sh80000000;
      end else begin
         upd_sat = 32'sh7FFFFFFF;
      end
   end

   // next-state selection per operation
   always_comb begin
      est_in  = est_ff;
      cov_in  = cov_ff;
      z_in    = z_ff;
      pmid_in = pmid_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      gain_in = gain_ff;
      diff_in = diff_ff;
      prod_in = prod_ff;
      out_in  = out_ff;
      if (ctrl.fire) begin
         case (ctrl.op)
            OP_WAIT: begin
               z_in    = {req_sample, 16'h0000};
               pmid_in = pred_sum[32] ? 32'hFFFFFFFF : pred_sum[31:0];
            end
            OP_DEN: begin
               den_in  = {1'b0, pmid_ff} + {1'b0, measurement_noise};
               rem_in  = {1'b0, pmid_ff};
               quo_in  = '0;
               diff_in = {z_ff[31], z_ff} - {est_ff[31], est_ff};
            end
            OP_DIV: begin
               rem_in = rem_ge ? 33'(rem_sh - den_ext) : rem_sh[32:0];
               quo_in = {quo_ff[GainWidth-2:0], rem_ge};
            end
            OP_GAIN: begin
               if (den_ff == '0) begin
                  gain_in = '0;
               end else if (den_ff == {1'b0, pmid_ff}) begin
                  // no measurement noise: gain of one saturates
                  gain_in = '1;
               end else begin
                  gain_in = quo_ff;
               end
            end
            OP_MUL_P: prod_in = mul_prod;
            OP_UPD_P: cov_in  = prod_ff[47:16];
            OP_MUL_X: prod_in = mul_prod;
            OP_UPD_X: begin
               est_in = upd_sat;
               out_in = upd_sat;
            end
            default: ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff <= '0;
         cov_ff <= '0;
      end else begin
         est_ff <= est_in;
         cov_ff <= cov_in;
      end
   end

   // working registers, no reset
   always_ff @(posedge clock) begin
      z_ff    <= z_in;
      pmid_ff <= pmid_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      gain_ff <= gain_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      out_ff  <= out_in;
   end

   assign rsp_estimate = out_ff;

   `SKF_ASSERT_NEXT(a_cov_shrinks, ctrl.fire && ctrl.op == OP_UPD_P,
      cov_ff <= $past(pmid_ff))
   `SKF_ASSERT_NEXT(a_zero_den_gain, ctrl.fire && ctrl.op == OP_GAIN && den_ff == '0,
      gain_ff == '0)
   `SKF_ASSERT_NEXT(a_est_between, ctrl.fire && ctrl.op == OP_UPD_X,
      (est_ff >= $past(est_ff) && est_ff <= $past(z_ff)) ||
      (est_ff <= $past(est_ff) && est_ff >= $past(z_ff)))

endmodule

[design/scalar_kalman_filter_top.sv]
// Channel   Ports                               Direction  Payload
// req       req_valid / req_ready               in         req_sample, s16 integer
// rsp       rsp_valid / rsp_ready               out        rsp_estimate, s32 Q16.16
// csr       csr_valid / csr_ready               in         csr_index, csr_data (Q, R)
//
// Each item runs through accept, setup, 16 quotient bits of the restoring
// divider (one per cycle), gain, then two multiply/writeback pairs on the shared
// 33x18 multiplier. A new sample is accepted only at the first microcode step.
// The final step holds while an earlier result still waits on rsp_ready.
// Reset clears estimate and covariance and loads Q = 400.0, R = 10.0.
`include "scalar_kalman_filter_top_assert.svh"

module scalar_kalman_filter_top
   import skf_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SampleWidth-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [EstWidth-1:0]    rsp_estimate,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CsrIndexWidth-1:0]      csr_index,
   input  logic [CsrDataWidth-1:0]       csr_data
);

   logic [CsrDataWidth-1:0] process_noise_ff, process_noise_in;
   logic [CsrDataWidth-1:0] measurement_noise_ff, measurement_noise_in;
   logic [PcWidth-1:0]      pc_ff, pc_in;
   logic [DivCntWidth-1:0]  cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   skf_uword_type           uword;
   skf_ctrl_type            ctrl;
   logic                    out_free;
   logic                    take;

   // configuration registers; unknown indexes are dropped
   assign csr_ready = 1'b1;
   always_comb begin
      process_noise_in     = process_noise_ff;
      measurement_noise_in = measurement_noise_ff;
      if (csr_valid) begin
         if (csr_index == REG_PROCESS_NOISE) begin
            process_noise_in = csr_data;
         end else if (csr_index == REG_MEASUREMENT_NOISE) begin
            measurement_noise_in = csr_data;
         end
      end
   end

   // microcode fetch and step control
   assign uword    = skf_ucode(pc_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (uword.op == OP_WAIT);

   always_comb begin
      ctrl.op = uword.op;
      case (uword.op)
         OP_WAIT: ctrl.fire = req_valid;
         OP_UPD_X: ctrl.fire = out_free;
         default: ctrl.fire = 1'b1;
      endcase
   end

   always_comb begin
      case (uword.cond)
         COND_NONE:     take = 1'b0;
         COND_NO_REQ:   take = !req_valid;
         COND_DIV_MORE: take = (cnt_ff != DivLast);
         COND_OUT_BUSY: take = !out_free;
         default:       take = 1'b0;
      endcase
   end

   // the last step falls through to step 0 by wrapping
   assign pc_in = take ? uword.target : pc_ff + PcWidth'(1);

   always_comb begin
      cnt_in = cnt_ff;
      if (uword.op == OP_DEN) begin
         cnt_in = '0;
      end else if (uword.op == OP_DIV) begin
         cnt_in = cnt_ff + DivCntWidth'(1);
      end
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.op == OP_UPD_X && ctrl.fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         process_noise_ff     <= ProcessNoiseReset;
         measurement_noise_ff <= MeasurementNoiseReset;
         pc_ff                <= STEP_WAIT;
         cnt_ff               <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         process_noise_ff     <= process_noise_in;
         measurement_noise_ff <= measurement_noise_in;
         pc_ff                <= pc_in;
         cnt_ff               <= cnt_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   skf_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .req_sample        (req_sample),
      .process_noise     (process_noise_ff),
      .measurement_noise (measurement_noise_ff),
      .rsp_estimate      (rsp_estimate)
   );

   `SKF_ASSERT_NEXT(a_accept_to_setup, req_valid && req_ready, pc_ff == STEP_DEN)
   `SKF_ASSERT_NOW(a_div_exit_count, pc_ff == STEP_DIV && pc_in != STEP_DIV,
      cnt_ff == DivLast)
   `SKF_ASSERT_NOW(a_rsp_from_update, $rose(rsp_valid_ff), $past(pc_ff) == STEP_UPD_X)

endmodule
